FILE: sv/tcp_reno_congestion_window_core_assert.svh
// assertion macros shared by the checker files
`ifndef TCP_RENO_CONGESTION_WINDOW_CORE_ASSERT_SVH
`define TCP_RENO_CONGESTION_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define TCPR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpr assertion failed");

// next-cycle implication, disabled while rst is high
`define TCPR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpr assertion failed");

`endif

FILE: sv/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg
// Types, register indexes and reset constants of the congestion window core.
// ----------------------------------------------------------------------------
package tcpr_pkg;

   localparam int WINDOW_BITS_DEF = 16;
   localparam int WINDOW_BITS_MAX = 32;
   localparam int WIDE_BITS       = WINDOW_BITS_MAX + 1;

   localparam int FIELD_BITS   = 16;
   localparam int TIMEOUT_BITS = 8;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [FIELD_BITS-1:0] CWND_RESET     = 16'd1;
   localparam logic [FIELD_BITS-1:0] SSTHRESH_RESET = 16'd64;

   localparam logic [7:0]            DUP_TRIG_RESET   = 8'd3;
   localparam logic [7:0]            TIMEOUT_RESET    = 8'd3;
   localparam logic [7:0]            AI_STEP_RESET    = 8'd1;
   localparam logic [FIELD_BITS-1:0] INIT_WIN_RESET   = 16'd1;
   localparam logic [FIELD_BITS-1:0] INIT_THRESH_RESET = 16'd64;

   typedef enum logic [1:0] {
      OP_RESTART      = 2'd0,
      OP_LOSS_CHECK   = 2'd1,
      OP_ROUND_UPDATE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      PH_SLOW_START  = 2'd0,
      PH_CONG_AVOID  = 2'd1,
      PH_FAST_RETX   = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODE        = 3'd0,
      CSR_DUP_TRIGGER = 3'd1,
      CSR_TIMEOUT     = 3'd2,
      CSR_AI_STEP     = 3'd3,
      CSR_INIT_WIN    = 3'd4,
      CSR_INIT_THRESH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                  mode;
      logic [7:0]            dup_ack_trigger;
      logic [7:0]            timeout_rounds;
      logic [7:0]            ai_step;
      logic [FIELD_BITS-1:0] initial_window;
      logic [FIELD_BITS-1:0] initial_threshold;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [TIMEOUT_BITS-1:0] timeout_left;
   } ctl_state_type;

endpackage

FILE: sv/tcp_reno_congestion_window_core.sv
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window_core
// Reno / NewReno congestion window, threshold, phase and timeout tracker.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event word (opcode, lost_pkts, dup_acks) per accepted
//   handshake; rsp_* returns exactly one result word per event, in order.
//   csr_* writes one configuration register per handshake; csr_ready is
//   always high, and writes are meant for times when no event is in flight.
// Path: an event taken on req_* goes into the input register and moves on
//   into the result register that drives rsp_* once the result slot is free.
// Throughput: one event per cycle while rsp_ready is high; the window state
//   sits by the single compute stage, so each event sees the last one's state.
// Stall: while the result register is full and rsp_ready is low, one more
//   event can wait in the input register; req_ready drops only when both
//   are full.
// Reset: synchronous and active high; clears both registers' valid flags,
//   loads window 1, threshold 64, slow start, no timeout, and the
//   register reset values.
// ----------------------------------------------------------------------------
module tcp_reno_congestion_window_core import tcpr_pkg::*; #(
   parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_opcode,
   input  logic [FIELD_BITS-1:0]   req_lost_pkts,
   input  logic [FIELD_BITS-1:0]   req_dup_acks,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [FIELD_BITS-1:0]   rsp_window,
   output logic [FIELD_BITS-1:0]   rsp_threshold,
   output logic [1:0]              rsp_phase,
   output logic                    rsp_loss_handled,
   output logic                    rsp_send_allowed,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]   csr_wdata
);

   cfg_type cfg;

   // input register
   logic                  in_valid_ff;
   opcode_type            op_ff;
   logic [FIELD_BITS-1:0] lost_ff;
   logic [FIELD_BITS-1:0] dups_ff;

   // window state
   logic [WINDOW_BITS-1:0] cwnd_ff;
   logic [WINDOW_BITS-1:0] ssthresh_ff;
   ctl_state_type          ctl_ff;

   logic [WINDOW_BITS-1:0] cwnd_in;
   logic [WINDOW_BITS-1:0] ssthresh_in;
   ctl_state_type          ctl_in;
   logic                   handled_in;

   // result register
   logic                  out_valid_ff;
   logic [FIELD_BITS-1:0] window_ff;
   logic [FIELD_BITS-1:0] threshold_ff;
   phase_type             phase_ff;
   logic                  handled_ff;
   logic                  send_ff;

   logic advance;

   tcpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcpr_next #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_next (
      .cfg           (cfg),
      .opcode        (op_ff),
      .lost_pkts     (lost_ff),
      .dup_acks      (dups_ff),
      .cwnd          (cwnd_ff),
      .ssthresh      (ssthresh_ff),
      .ctl           (ctl_ff),
      .cwnd_next     (cwnd_in),
      .ssthresh_next (ssthresh_in),
      .ctl_next      (ctl_in),
      .loss_handled  (handled_in)
   );

   // the event in the input register moves on when the result slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= opcode_type'(req_opcode);
         lost_ff <= req_lost_pkts;
         dups_ff <= req_dup_acks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff             <= WINDOW_BITS'(CWND_RESET);
         ssthresh_ff         <= WINDOW_BITS'(SSTHRESH_RESET);
         ctl_ff.phase        <= PH_SLOW_START;
         ctl_ff.timeout_left <= '0;
      end else if (advance) begin
         cwnd_ff     <= cwnd_in;
         ssthresh_ff <= ssthresh_in;
         ctl_ff      <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff    <= FIELD_BITS'(cwnd_in);
         threshold_ff <= FIELD_BITS'(ssthresh_in);
         phase_ff     <= ctl_in.phase;
         handled_ff   <= handled_in;
         send_ff      <= (ctl_in.timeout_left == '0);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_window       = window_ff;
   assign rsp_threshold    = threshold_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_loss_handled = handled_ff;
   assign rsp_send_allowed = send_ff;

endmodule

FILE: sv/tcpr_csr.sv
// ----------------------------------------------------------------------------
// tcpr_csr
// Configuration registers, written through the csr word channel.
// ----------------------------------------------------------------------------
module tcpr_csr import tcpr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]   csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:        cfg_in.mode              = csr_wdata[0];
            CSR_DUP_TRIGGER: cfg_in.dup_ack_trigger   = csr_wdata[7:0];
            CSR_TIMEOUT:     cfg_in.timeout_rounds    = csr_wdata[7:0];
            CSR_AI_STEP:     cfg_in.ai_step           = csr_wdata[7:0];
            CSR_INIT_WIN:    cfg_in.initial_window    = csr_wdata;
            CSR_INIT_THRESH: cfg_in.initial_threshold = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= 1'b0;
         cfg_ff.dup_ack_trigger   <= DUP_TRIG_RESET;
         cfg_ff.timeout_rounds    <= TIMEOUT_RESET;
         cfg_ff.ai_step           <= AI_STEP_RESET;
         cfg_ff.initial_window    <= INIT_WIN_RESET;
         cfg_ff.initial_threshold <= INIT_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/tcpr_next.sv
// ----------------------------------------------------------------------------
// tcpr_next
// Next window, threshold, phase and timeout count for one event.
// ----------------------------------------------------------------------------
module tcpr_next import tcpr_pkg::*; #(
   parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
   input  cfg_type                 cfg,
   input  opcode_type              opcode,
   input  logic [FIELD_BITS-1:0]   lost_pkts,
   input  logic [FIELD_BITS-1:0]   dup_acks,
   input  logic [WINDOW_BITS-1:0]  cwnd,
   input  logic [WINDOW_BITS-1:0]  ssthresh,
   input  ctl_state_type           ctl,
   output logic [WINDOW_BITS-1:0]  cwnd_next,
   output logic [WINDOW_BITS-1:0]  ssthresh_next,
   output ctl_state_type           ctl_next,
   output logic                    loss_handled
);

   localparam logic [WIDE_BITS-1:0] WinMaxWide = WIDE_BITS'({WINDOW_BITS{1'b1}});

   logic [WIDE_BITS-1:0]   init_win_wide;
   logic [WIDE_BITS-1:0]   init_thr_wide;
   logic [WINDOW_BITS-1:0] init_win_sat;
   logic [WINDOW_BITS-1:0] init_thr_sat;
   logic [WINDOW_BITS-1:0] cut_thr;
   logic [WINDOW_BITS:0]   dbl;
   logic [WINDOW_BITS:0]   ai_sum;
   logic [WINDOW_BITS-1:0] ai_sat;

   always_comb begin
      // restart values clamp to the window width
      init_win_wide = WIDE_BITS'(cfg.initial_window);
      init_thr_wide = WIDE_BITS'(cfg.initial_threshold);
      init_win_sat  = (init_win_wide > WinMaxWide) ? WINDOW_BITS'(WinMaxWide)
                                                   : WINDOW_BITS'(init_win_wide);
      init_thr_sat  = (init_thr_wide > WinMaxWide) ? WINDOW_BITS'(WinMaxWide)
                                                   : WINDOW_BITS'(init_thr_wide);

      if (cfg.mode) begin
         cut_thr = cwnd >> 1;
      end else if (lost_pkts >= FIELD_BITS'(WINDOW_BITS)) begin
         cut_thr = '0;
      end else begin
         cut_thr = cwnd >> lost_pkts;
      end

      dbl    = {1'b0, cwnd} + {1'b0, cwnd};
      ai_sum = {1'b0, cwnd} + (WINDOW_BITS+1)'(cfg.ai_step);
      ai_sat = ai_sum[WINDOW_BITS] ? {WINDOW_BITS{1'b1}} : ai_sum[WINDOW_BITS-1:0];
   end

   always_comb begin
      cwnd_next     = cwnd;
      ssthresh_next = ssthresh;
      ctl_next      = ctl;
      loss_handled  = 1'b0;
      case (opcode)
         OP_RESTART: begin
            cwnd_next             = init_win_sat;
            ssthresh_next         = init_thr_sat;
            ctl_next.phase        = PH_SLOW_START;
            ctl_next.timeout_left = '0;
         end
         OP_LOSS_CHECK: begin
            if (ctl.timeout_left != '0) begin
               ctl_next.timeout_left = ctl.timeout_left - 1'b1;
               loss_handled          = 1'b1;
            end else if (dup_acks >= FIELD_BITS'(cfg.dup_ack_trigger)) begin
               ctl_next.phase = PH_FAST_RETX;
               ssthresh_next  = cut_thr;
               cwnd_next      = cut_thr;
               loss_handled   = 1'b1;
            end else if (lost_pkts != '0) begin
               ctl_next.timeout_left = cfg.timeout_rounds;
               ctl_next.phase        = PH_SLOW_START;
               ssthresh_next         = cut_thr;
               cwnd_next             = WINDOW_BITS'(1);
               loss_handled          = 1'b1;
            end
         end
         OP_ROUND_UPDATE: begin
            case (ctl.phase)
               PH_FAST_RETX, PH_CONG_AVOID: begin
                  ctl_next.phase = PH_CONG_AVOID;
                  cwnd_next      = ai_sat;
               end
               PH_SLOW_START: begin
                  // doubling stops at the threshold
                  if (dbl >= {1'b0, ssthresh}) begin
                     cwnd_next      = ssthresh;
                     ctl_next.phase = PH_CONG_AVOID;
                  end else begin
                     cwnd_next = dbl[WINDOW_BITS-1:0];
                  end
               end
               default: ctl_next = ctl;
            endcase
         end
         default: loss_handled = 1'b0;
      endcase
   end

endmodule

FILE: sv/tcpr_checker.sv
// ----------------------------------------------------------------------------
// tcpr_checker
// Port-level checks of the congestion window core, bound to the top level.
// ----------------------------------------------------------------------------
`include "tcp_reno_congestion_window_core_assert.svh"

module tcpr_checker import tcpr_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [FIELD_BITS-1:0]   rsp_window,
   input logic [FIELD_BITS-1:0]   rsp_threshold,
   input logic [1:0]              rsp_phase,
   input logic                    rsp_send_allowed
);

   // a stalled result word holds
   `TCPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_window) && $stable(rsp_threshold))

   // no result word right after reset
   `TCPR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // fast retransmit always sits with window equal to threshold and no timeout
   `TCPR_ASSERT_NOW(a_fast_retx, clock, reset, rsp_valid && (rsp_phase == PH_FAST_RETX), (rsp_window == rsp_threshold) && rsp_send_allowed)

   // a draining result side never blocks new events
   `TCPR_ASSERT_NOW(a_no_bubble, clock, reset, rsp_ready, req_ready)

endmodule

bind tcp_reno_congestion_window_core tcpr_checker u_tcpr_checker (.*);
